// ===== sv/bwdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwdp_pkg
// shared types, constants and binary32 arithmetic for the bf16 weight dot
// product block
// ----------------------------------------------------------------------------
package bwdp_pkg;

    localparam int MaxLength  = 4096;
    localparam int LenWidth   = 13;
    localparam int DataWidth  = 32;
    localparam int CfgIdxWidth = 8;
    localparam int QueueDepth = 2;

    localparam logic [CfgIdxWidth-1:0] REG_VECTOR_LENGTH = 8'd0;
    localparam logic [CfgIdxWidth-1:0] REG_WEIGHT_FORMAT = 8'd1;
    localparam logic [CfgIdxWidth-1:0] REG_LANE_MODE     = 8'd2;
    localparam logic [CfgIdxWidth-1:0] REG_OUTPUT_SCALE  = 8'd3;

    localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;
    localparam logic [31:0] FP_ZERO  = 32'h0000_0000;

    typedef struct packed {
        logic       use_lane;
        logic [1:0] lane;
        logic       merge;
        logic       last;
    } elem_ctl_t;

    typedef struct packed {
        logic [31:0] act;
        logic [31:0] wgt;
        elem_ctl_t   ctl;
    } queue_entry_t;

    // leading zeros of a 50-bit word
    function automatic logic [5:0] lzc50(input logic [49:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd0;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n = 6'(49 - i);
            end
        end
        return n;
    endfunction

    // mant has its leading one at bit 47 (value 1.x), e is the biased exponent
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [11:0] e,
                                               input logic [47:0] mant);
        logic [63:0] ext;
        logic [63:0] shifted;
        logic [63:0] mask;
        logic [11:0] sh;
        logic [23:0] m;
        logic        g;
        logic        s;
        logic [7:0]  ef;
        logic [24:0] m25;
        logic [31:0] tot;
        ext = {mant, 16'b0};
        shifted = ext;
        mask = 64'b0;
        sh = 12'd0;
        if (e >= 12'sd255) begin
            return {sign, 8'hFF, 23'b0};
        end
        if (e < 12'sd1) begin
            // subnormal result, shift right keeping sticky
            sh = 12'(12'sd1 - e);
            if (sh > 12'd63) sh = 12'd63;
            shifted = ext >> sh[5:0];
            mask = ~({64{1'b1}} << sh[5:0]);
            m = shifted[63:40];
            g = shifted[39];
            s = (|shifted[38:0]) | (|(ext & mask));
            ef = 8'd0;
        end else begin
            m = mant[47:24];
            g = mant[23];
            s = |mant[22:0];
            ef = 8'(e - 12'sd1);
        end
        m25 = {1'b0, m} + 25'(g & (s | m[0]));
        tot = {1'b0, ef, 23'b0} + {7'b0, m25};
        return {sign, tot[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sr;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        logic [5:0]  lz;
        logic [47:0] pn;
        logic signed [11:0] e;
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        sr = a[31] ^ b[31];
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
        a_zero = (a[30:0] == 31'b0);
        b_zero = (b[30:0] == 31'b0);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return FP_QNAN;
        if (a_inf || b_inf) return {sr, 8'hFF, 23'b0};
        if (a_zero || b_zero) return {sr, 31'b0};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p = ma * mb;
        lz = lzc50({p, 2'b0});
        pn = p << lz;
        e = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126 - $signed({6'b0, lz});
        return round_pack(sr, e, pn);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [23:0] mx;
        logic [23:0] my;
        logic [7:0]  d;
        logic [49:0] av;
        logic [49:0] bv;
        logic [49:0] bs;
        logic [49:0] sum;
        logic [49:0] nrm;
        logic [5:0]  lz;
        logic        st;
        logic signed [11:0] e;
        logic a_nan, b_nan, a_inf, b_inf;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return FP_QNAN;
        if (a_inf) return a;
        if (b_inf) return b;
        if ((a[30:0] == 31'b0) && (b[30:0] == 31'b0)) return {a[31] & b[31], 31'b0};
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};
        d = ex - ey;
        av = {1'b0, mx, 25'b0};
        bv = {1'b0, my, 25'b0};
        if (d >= 8'd50) begin
            bs = 50'b0;
            st = |my;
        end else begin
            bs = bv >> d;
            st = ((bs << d) != bv);
        end
        bs[0] = bs[0] | st;
        sum = (x[31] == y[31]) ? (av + bs) : (av - bs);
        if (sum == 50'b0) return FP_ZERO;
        lz = lzc50(sum);
        nrm = sum << lz;
        e = $signed({4'b0, ex}) + 12'sd1 - $signed({6'b0, lz});
        return round_pack(x[31], e, {nrm[49:3], |nrm[2:0]});
    endfunction

endpackage

// ===== sv/bwdp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwdp_front
// accepts element pairs, widens a bf16 weight to fp32 and tags each element with its
// lane, merge and end-of-vector marks
// ----------------------------------------------------------------------------
module bwdp_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bwdp_pkg::LenWidth-1:0]   vector_length,
    input  logic                            weight_format,
    input  logic                            lane_mode,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_activation,
    input  logic [31:0]                     s_weight_value,
    input  logic                            q_full,
    output logic                            q_push,
    output bwdp_pkg::queue_entry_t          q_data
);

    logic [bwdp_pkg::LenWidth-1:0] count_reg;
    logic [bwdp_pkg::LenWidth-1:0] count_next;
    logic [bwdp_pkg::LenWidth-1:0] len_eff;
    logic [bwdp_pkg::LenWidth-1:0] full_len;
    logic [bwdp_pkg::LenWidth-1:0] idx_inc;
    bwdp_pkg::elem_ctl_t           ctl;

    always_comb begin
        if (vector_length == '0)
            len_eff = bwdp_pkg::LenWidth'(1);
        else if (vector_length > bwdp_pkg::LenWidth'(bwdp_pkg::MaxLength))
            len_eff = bwdp_pkg::LenWidth'(bwdp_pkg::MaxLength);
        else
            len_eff = vector_length;
        full_len     = {len_eff[bwdp_pkg::LenWidth-1:2], 2'b00};
        idx_inc      = count_reg + bwdp_pkg::LenWidth'(1);
        ctl.use_lane = !lane_mode && (count_reg < full_len);
        ctl.lane     = count_reg[1:0];
        ctl.merge    = ctl.use_lane && (idx_inc == full_len);
        ctl.last     = (idx_inc >= len_eff);
        count_next   = ctl.last ? '0 : idx_inc;
    end

    assign s_ready    = !q_full;
    assign q_push     = s_valid && s_ready;
    assign q_data.act = s_activation;
    assign q_data.wgt = weight_format ? s_weight_value : {s_weight_value[15:0], 16'h0000};
    assign q_data.ctl = ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (q_push) begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/bwdp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwdp_queue
// two-entry element queue between the front and the back
// ----------------------------------------------------------------------------
module bwdp_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  bwdp_pkg::queue_entry_t wr_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output bwdp_pkg::queue_entry_t rd_data
);

    bwdp_pkg::queue_entry_t slot_reg [bwdp_pkg::QueueDepth];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = (fill_reg == 2'(bwdp_pkg::QueueDepth));
    assign not_empty = (fill_reg != 2'd0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== sv/bwdp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwdp_back
// multiply, accumulate, lane merge, final scaling; one step per cycle unless output stalls
// ----------------------------------------------------------------------------
module bwdp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [31:0]            output_scale,
    input  logic                   q_not_empty,
    input  bwdp_pkg::queue_entry_t q_data,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_dot_product
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_M1    = 3'd3;
    localparam logic [2:0] S_M2    = 3'd4;
    localparam logic [2:0] S_M3    = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [31:0]          act_reg;
    logic [31:0]          wgt_reg;
    bwdp_pkg::elem_ctl_t  ctl_reg;
    logic [31:0]          prod_reg;
    logic [31:0]          lane_reg [4];
    logic [31:0]          merged_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_reg;
    logic                 out_free;

    assign out_free      = !out_valid_reg || m_ready;
    assign q_pop         = (state_reg == S_IDLE) && q_not_empty;
    assign m_valid       = out_valid_reg;
    assign m_dot_product = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_not_empty) state_next = S_MUL;
            S_MUL:   state_next = S_ADD;
            S_ADD: begin
                if (ctl_reg.merge)     state_next = S_M1;
                else if (ctl_reg.last) state_next = S_SCALE;
                else                   state_next = S_IDLE;
            end
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = ctl_reg.last ? S_SCALE : S_IDLE;
            S_SCALE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            merged_reg    <= bwdp_pkg::FP_ZERO;
            for (int i = 0; i < 4; i++) lane_reg[i] <= bwdp_pkg::FP_ZERO;
        end else begin
            state_reg <= state_next;
            if (m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_ADD: begin
                    if (ctl_reg.use_lane)
                        lane_reg[ctl_reg.lane] <= bwdp_pkg::fp_add(lane_reg[ctl_reg.lane],
                                                                   prod_reg);
                    else
                        merged_reg <= bwdp_pkg::fp_add(merged_reg, prod_reg);
                end
                S_M1: merged_reg <= bwdp_pkg::fp_add(lane_reg[0], lane_reg[1]);
                S_M2: merged_reg <= bwdp_pkg::fp_add(merged_reg, lane_reg[2]);
                S_M3: merged_reg <= bwdp_pkg::fp_add(merged_reg, lane_reg[3]);
                S_SCALE: begin
                    if (out_free) begin
                        // vector done: hand off result and clear accumulators
                        out_valid_reg <= 1'b1;
                        merged_reg    <= bwdp_pkg::FP_ZERO;
                        for (int i = 0; i < 4; i++) lane_reg[i] <= bwdp_pkg::FP_ZERO;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            act_reg <= q_data.act;
            wgt_reg <= q_data.wgt;
            ctl_reg <= q_data.ctl;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= bwdp_pkg::fp_mul(act_reg, wgt_reg);
        end
        if ((state_reg == S_SCALE) && out_free) begin
            out_reg <= bwdp_pkg::fp_mul(merged_reg, output_scale);
        end
    end

endmodule

// ===== sv/bf16_weight_dot_product_top.sv =====
`timescale 1ns / 1ps
// sequence: each element passes dequeue, multiply and add in the back, followed by
// the lane merge after the last full group and scaling on the last element
// flow: the back takes no new element until the last one and any merge or scaling
// are done; the 2-entry queue lets the input run ahead by two elements
// reset: aresetn synchronous active low, clears accumulators, count, queue and
// output valid, registers go to length 1, bf16 weights, four lanes, scale 1.0
// ----------------------------------------------------------------------------
// bf16_weight_dot_product_top
// streaming fp32 dot product with bf16 or fp32 weights and output scaling
// ----------------------------------------------------------------------------
module bf16_weight_dot_product_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bwdp_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [31:0]                        s_activation,
    input  logic [31:0]                        s_weight_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [31:0]                        m_dot_product
);

    logic [bwdp_pkg::LenWidth-1:0] vector_length_reg;
    logic                          weight_format_reg;
    logic                          lane_mode_reg;
    logic [31:0]                   output_scale_reg;

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_not_empty;
    bwdp_pkg::queue_entry_t q_wr_data;
    bwdp_pkg::queue_entry_t q_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_length_reg <= bwdp_pkg::LenWidth'(1);
            weight_format_reg <= 1'b0;
            lane_mode_reg     <= 1'b0;
            output_scale_reg  <= bwdp_pkg::FP_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bwdp_pkg::REG_VECTOR_LENGTH:
                    vector_length_reg <= cfg_data[bwdp_pkg::LenWidth-1:0];
                bwdp_pkg::REG_WEIGHT_FORMAT: weight_format_reg <= cfg_data[0];
                bwdp_pkg::REG_LANE_MODE:     lane_mode_reg     <= cfg_data[0];
                bwdp_pkg::REG_OUTPUT_SCALE:  output_scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    bwdp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .vector_length  (vector_length_reg),
        .weight_format  (weight_format_reg),
        .lane_mode      (lane_mode_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_activation   (s_activation),
        .s_weight_value (s_weight_value),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wr_data)
    );

    bwdp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    bwdp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .output_scale  (output_scale_reg),
        .q_not_empty   (q_not_empty),
        .q_data        (q_rd_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dot_product (m_dot_product)
    );

endmodule

// ===== sv/bwdp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwdp_checker
// port-level checks for the dot product block
// ----------------------------------------------------------------------------
module bwdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_dot_product
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue is empty after reset, so the input side is open
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dot_product))
        else $error("stalled result changed");

    // every nan leaves as the canonical quiet nan
    a_nan_canon: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_dot_product[30:23] == 8'hFF) && (m_dot_product[22:0] != 23'd0)
        |-> m_dot_product == 32'h7FC0_0000)
        else $error("non-canonical nan");

    // a result cannot appear before an element is queued, multiplied and added after reset
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(aresetn, 3))
        else $error("result too soon after reset");

endmodule

bind bf16_weight_dot_product_top bwdp_checker u_bwdp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_dot_product (m_dot_product)
);

// ===== tb/sv/tb_bf16_weight_dot_product_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bf16_weight_dot_product_top
// self-checking bench for the bf16 weight dot product: a bit-exact binary32
// predictor tracks lanes, merge and scaling, results are checked in order
// under random gaps and output stalls across lengths, formats and lane modes
// ----------------------------------------------------------------------------
module tb_bf16_weight_dot_product_top;

    localparam int WatchLimit = 5000;
    localparam int DrainCycles = 20;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [bwdp_pkg::CfgIdxWidth-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_activation;
    logic [31:0] s_weight_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_dot_product;

    bf16_weight_dot_product_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_activation(s_activation), .s_weight_value(s_weight_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_dot_product(m_dot_product)
    );

    // predictor state and register copy
    logic [31:0] lane_acc [4];
    logic [31:0] tail_acc;
    int          elem_idx;
    logic [12:0] len_reg;
    logic        fmt_reg;
    logic        mode_reg;
    logic [31:0] scale_reg;

    logic [31:0] dot_expected [$];
    int  error_count;
    int  items_sent;
    int  results_seen;
    int  idle_cycles;
    bit  stall_enable;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------ fp32
    function automatic logic [31:0] pack_rne(input logic sign, input int e,
                                             input logic [63:0] m);
        logic [63:0]  n;
        logic [127:0] wide;
        logic [23:0]  k;
        logic         g;
        logic         s;
        logic [31:0]  tot;
        int           lz;
        int           be;
        int           sh;
        n = m;
        lz = 0;
        while (!n[63]) begin
            n = n << 1;
            lz++;
        end
        be = e + 63 - lz + 127;
        if (be >= 255) return {sign, 8'hFF, 23'b0};
        if (be >= 1) begin
            k = n[63:40];
            g = n[39];
            s = |n[38:0];
            tot = {1'b0, 8'(be - 1), 23'b0} + {8'b0, k};
        end else begin
            sh = 1 - be;
            if (sh > 110) sh = 110;
            wide = {n, 64'b0} >> sh;
            k = wide[127:104];
            g = wide[103];
            s = |wide[102:0];
            tot = {8'b0, k};
        end
        tot = tot + 32'(g & (s | k[0]));
        return {sign, tot[30:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 0);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic sg;
        int   ea;
        int   eb;
        logic [63:0] p;
        sg = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 0) ||
            (is_inf(b) && a[30:0] == 0)) return bwdp_pkg::FP_QNAN;
        if (is_inf(a) || is_inf(b)) return {sg, 8'hFF, 23'b0};
        if (a[30:0] == 0 || b[30:0] == 0) return {sg, 31'b0};
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        p = 64'({a[30:23] != 0, a[22:0]}) * 64'({b[30:23] != 0, b[22:0]});
        return pack_rne(sg, ea - 150 + eb - 150, p);
    endfunction

    function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        int   ex;
        int   ey;
        int   d;
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] ys;
        logic [63:0] sum;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
            return bwdp_pkg::FP_QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        mx = 64'({x[30:23] != 0, x[22:0]}) << 30;
        my = 64'({y[30:23] != 0, y[22:0]}) << 30;
        d = ex - ey;
        if (d > 60) begin
            ys = (my != 0) ? 64'd1 : 64'd0;
        end else begin
            ys = my >> d;
            if ((ys << d) != my) ys[0] = 1'b1;
        end
        sum = (x[31] == y[31]) ? mx + ys : mx - ys;
        if (sum == 0) return bwdp_pkg::FP_ZERO;
        return pack_rne(x[31], ex - 150 - 30, sum);
    endfunction

    // ------------------------------------------------------------ predictor
    function automatic void clear_accumulators();
        for (int i = 0; i < 4; i++) lane_acc[i] = bwdp_pkg::FP_ZERO;
        tail_acc = bwdp_pkg::FP_ZERO;
        elem_idx = 0;
    endfunction

    function automatic void accumulate_element(input logic [31:0] act,
                                               input logic [31:0] wgt);
        int          len;
        int          full;
        logic [31:0] prod;
        logic [31:0] res;
        len = int'(len_reg);
        if (len == 0) len = 1;
        if (len > bwdp_pkg::MaxLength) len = bwdp_pkg::MaxLength;
        prod = mul32(act, fmt_reg ? wgt : {wgt[15:0], 16'b0});
        full = len & ~3;
        if (!mode_reg && elem_idx < full) begin
            lane_acc[elem_idx % 4] = add32(lane_acc[elem_idx % 4], prod);
            if (elem_idx + 1 == full)
                tail_acc = add32(add32(add32(lane_acc[0], lane_acc[1]), lane_acc[2]),
                                 lane_acc[3]);
        end else begin
            tail_acc = add32(tail_acc, prod);
        end
        elem_idx++;
        if (elem_idx >= len) begin
            res = mul32(tail_acc, scale_reg);
            if (is_nan(res)) res = bwdp_pkg::FP_QNAN;
            dot_expected.push_back(res);
            clear_accumulators();
        end
    endfunction

    // -------------------------------------------------------------- drivers
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_fp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return {1'($urandom), 8'($urandom_range(112, 142)), 23'($urandom)};
        if (r < 85) begin
            case ($urandom_range(0, 5))
                0: return 32'h7F80_0000;
                1: return 32'hFF80_0000;
                2: return 32'h7FC0_0001;
                3: return {1'($urandom), 31'b0};
                4: return {1'($urandom), 8'h00, 23'($urandom)};
                default: return 32'h7F7F_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_moderate();
        return {1'($urandom), 8'($urandom_range(120, 130)), 23'($urandom)};
    endfunction

    task automatic send_element(input logic [31:0] act, input logic [31:0] wgt,
                                input int gap);
        s_valid <= 1'b1;
        s_activation <= act;
        s_weight_value <= wgt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accumulate_element(act, wgt);
        items_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic finish_sending();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (dot_expected.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bwdp_pkg::CfgIdxWidth-1:0] idx,
                             input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bwdp_pkg::REG_VECTOR_LENGTH: len_reg = val[12:0];
            bwdp_pkg::REG_WEIGHT_FORMAT: fmt_reg = val[0];
            bwdp_pkg::REG_LANE_MODE:     mode_reg = val[0];
            bwdp_pkg::REG_OUTPUT_SCALE:  scale_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input int len, input logic fmt, input logic mode,
                              input logic [31:0] scale);
        finish_sending();
        wait_drained();
        write_reg(bwdp_pkg::REG_VECTOR_LENGTH, 32'(len));
        write_reg(bwdp_pkg::REG_WEIGHT_FORMAT, {31'b0, fmt});
        write_reg(bwdp_pkg::REG_LANE_MODE, {31'b0, mode});
        write_reg(bwdp_pkg::REG_OUTPUT_SCALE, scale);
    endtask

    task automatic send_random_vectors(input int count);
        for (int i = 0; i < count; i++) send_element(rand_fp(), rand_fp(), rand_gap());
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_special_values();
        // length 1 straight after reset: bf16, four lanes, scale one
        send_element(32'h3F80_0000, 32'hABCD_3F80, 0); // upper weight bits ignored
        send_element(32'h7F80_0000, 32'h0000_0000, 0); // inf times zero
        send_element(32'h7FC0_1234, 32'h0000_3F80, 1); // nan in
        send_element(32'hFF80_0000, 32'h0000_4000, 0);
        send_element(32'h7F7F_FFFF, 32'h0000_7F7F, 0); // overflow
        send_element(32'h0000_0001, 32'h0000_3F00, 2); // subnormal rounds
        send_element(32'h8000_0000, 32'h0000_0000, 0);
        send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_element(32'h0000_0000, 32'h0000_0000, 0);
        // zero length acts as one, fp32 weights, nan scale
        set_config(0, 1'b1, 1'b0, 32'h7F80_0001);
        send_element(32'h3F80_0000, 32'h4000_0000, 0);
        finish_sending();
        wait_drained();
        write_reg(bwdp_pkg::REG_OUTPUT_SCALE, 32'h0000_0000);
        send_element(32'h7F80_0000, 32'h3F80_0000, 0);
        // tails after a full group, lanes and sequential
        set_config(7, 1'b0, 1'b0, 32'h3EB5_04F3);
        send_random_vectors(7);
        set_config(6, 1'b1, 1'b1, 32'h7F7F_FFFF);
        send_random_vectors(6);
    endtask

    task automatic test_long_vectors();
        // many full lane groups, then a long sequential vector
        set_config(64, 1'b0, 1'b0, 32'h3E00_0000);
        for (int i = 0; i < 64; i++)
            send_element(rand_moderate(), $urandom, (i < 16) ? rand_gap() : 0);
        set_config(61, 1'b1, 1'b1, bwdp_pkg::FP_ONE);
        for (int i = 0; i < 61; i++)
            send_element(rand_moderate(), rand_moderate(), 0);
    endtask

    task automatic test_random_streams();
        int budget;
        int len;
        int nvec;
        logic [31:0] scale;
        budget = 280;
        while (budget > 0) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            case ($urandom_range(0, 3))
                0: scale = bwdp_pkg::FP_ONE;
                1: scale = 32'h3E80_0000;
                2: scale = 32'h3EB5_04F3;
                default: scale = rand_fp();
            endcase
            set_config(len, 1'($urandom), 1'($urandom), scale);
            stall_enable = ($urandom_range(0, 3) != 0);
            nvec = $urandom_range(1, 4);
            send_random_vectors(len * nvec);
            budget -= len * nvec;
            if ($urandom_range(0, 4) == 0) begin
                // hold off until the block has emptied
                finish_sending();
                wait_drained();
            end
        end
        stall_enable = 1'b1;
    endtask

    // ------------------------------------------------------- result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (dot_expected.size() == 0) begin
                $display("%0t: unexpected dot_product transfer, actual %h", $realtime,
                         m_dot_product);
                error_count++;
            end else begin
                if (m_dot_product !== dot_expected[0]) begin
                    $display("%0t: dot_product mismatch, expected %h actual %h",
                             $realtime, dot_expected[0], m_dot_product);
                    error_count++;
                end
                void'(dot_expected.pop_front());
            end
        end
    end

    // output back-pressure
    always @(posedge aclk) begin
        if (!aresetn || !stall_enable) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            m_ready <= 1'b0;
        end else if (!m_ready) begin
            m_ready <= ($urandom_range(0, 9) < 2);
        end else begin
            m_ready <= ($urandom_range(0, 9) != 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("%0t: watchdog expired with %0d results pending", $realtime,
                         dot_expected.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_activation = '0;
        s_weight_value = '0;
        m_ready = 1'b1;
        stall_enable = 1'b0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        len_reg = 13'd1;
        fmt_reg = 1'b0;
        mode_reg = 1'b0;
        scale_reg = bwdp_pkg::FP_ONE;
        clear_accumulators();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        stall_enable = 1'b1;

        test_special_values();
        test_long_vectors();
        test_random_streams();

        finish_sending();
        wait_drained();
        $display("covered %0d element transfers and %0d dot products", items_sent,
                 results_seen);
        $display("lengths 0 to 64, bf16 and fp32 weights, lane and sequential modes");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bwdp_pkg.sv
sv/bwdp_front.sv
sv/bwdp_queue.sv
sv/bwdp_back.sv
sv/bf16_weight_dot_product_top.sv
sv/bwdp_checker.sv
tb/sv/tb_bf16_weight_dot_product_top.sv
